// ===== hw/rtl/fixed_point_alu_unit_defines.svh =====
// Assertion macros for the fixed-point ALU.
// Used by the top level; expects clk and rst in the enclosing scope.
`ifndef FIXED_POINT_ALU_UNIT_DEFINES_SVH
`define FIXED_POINT_ALU_UNIT_DEFINES_SVH

// Condition that must hold at every edge outside reset.
`define FPA_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define FPA_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/fpa_pkg.sv =====
// Shared constants, opcodes and pipeline payload types for the fixed-point ALU.
// No dependencies.
package fpa_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 8;
  // magnitude bits of the widened dividend, one divider cell per bit
  localparam int DIV_W     = DATA_W + FRAC_BITS;
  localparam int KIND_W    = 4;

  typedef enum logic [KIND_W-1:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } op_t;

  typedef struct packed {
    logic                  is_mul;
    logic                  is_div;
    logic [2*DATA_W-1:0]   prod;
    logic [DATA_W-1:0]     res;
    logic                  flag;
    logic                  dz;
    logic                  neg;
    logic [DIV_W-1:0]      dvd;
    logic [DATA_W-1:0]     dvs;
  } front_t;

  // Payload carried along the divider chain. Non-divide results ride in q.
  typedef struct packed {
    logic                  is_div;
    logic                  dz;
    logic                  neg;
    logic                  flag;
    logic [DATA_W-1:0]     rem;
    logic [DIV_W-1:0]      dvd;
    logic [DATA_W-1:0]     dvs;
    logic [DATA_W-1:0]     q;
  } cell_t;

endpackage

// ===== hw/rtl/fpa_front.sv =====
// Entry stage: decodes the opcode, computes every result but multiply and divide,
// the full product and the divider operands. Depends on fpa_pkg.
module fpa_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                advance,
  input  logic                                in_valid,
  input  logic [fpa_pkg::KIND_W-1:0]          kind,
  input  logic signed [fpa_pkg::DATA_W-1:0]   operand_a,
  input  logic signed [fpa_pkg::DATA_W-1:0]   operand_b,
  output logic                                out_valid,
  output fpa_pkg::front_t                     out_data
);

  fpa_pkg::op_t                            op;
  fpa_pkg::front_t                         data_next;
  logic signed [2*fpa_pkg::DATA_W-1:0]     prod_c;
  logic signed [fpa_pkg::DATA_W-1:0]       bias;
  logic signed [fpa_pkg::DATA_W-1:0]       biased;
  logic signed [fpa_pkg::DATA_W-1:0]       to_int_c;
  logic [fpa_pkg::DATA_W-1:0]              abs_a;
  logic [fpa_pkg::DATA_W-1:0]              abs_b;
  logic                                    gt;
  logic                                    lt;

  always_comb begin
    op       = fpa_pkg::op_t'(kind);
    prod_c   = (2*fpa_pkg::DATA_W)'(operand_a) * (2*fpa_pkg::DATA_W)'(operand_b);
    gt       = operand_a > operand_b;
    lt       = operand_a < operand_b;
    // round toward zero: bias negatives by one LSB short of the divisor
    bias     = operand_a[fpa_pkg::DATA_W-1]
               ? fpa_pkg::DATA_W'((1 << fpa_pkg::FRAC_BITS) - 1) : '0;
    biased   = operand_a + bias;
    to_int_c = biased >>> fpa_pkg::FRAC_BITS;
    abs_a    = operand_a[fpa_pkg::DATA_W-1] ? fpa_pkg::DATA_W'(-operand_a)
                                            : fpa_pkg::DATA_W'(operand_a);
    abs_b    = operand_b[fpa_pkg::DATA_W-1] ? fpa_pkg::DATA_W'(-operand_b)
                                            : fpa_pkg::DATA_W'(operand_b);

    data_next        = '0;
    data_next.prod   = prod_c;
    data_next.is_mul = (op == fpa_pkg::OP_MUL);
    data_next.is_div = (op == fpa_pkg::OP_DIV);
    data_next.dz     = (op == fpa_pkg::OP_DIV) && (operand_b == '0);
    data_next.neg    = operand_a[fpa_pkg::DATA_W-1] ^ operand_b[fpa_pkg::DATA_W-1];
    data_next.dvd    = fpa_pkg::DIV_W'(abs_a) << fpa_pkg::FRAC_BITS;
    data_next.dvs    = abs_b;

    case (op)
      fpa_pkg::OP_ADD:      data_next.res = operand_a + operand_b;
      fpa_pkg::OP_SUB:      data_next.res = operand_a - operand_b;
      fpa_pkg::OP_GT:       data_next.flag = gt;
      fpa_pkg::OP_LT:       data_next.flag = lt;
      fpa_pkg::OP_GE:       data_next.flag = !lt;
      fpa_pkg::OP_LE:       data_next.flag = !gt;
      fpa_pkg::OP_EQ:       data_next.flag = (operand_a == operand_b);
      fpa_pkg::OP_NE:       data_next.flag = (operand_a != operand_b);
      fpa_pkg::OP_MIN:      data_next.res = lt ? operand_a : operand_b;
      fpa_pkg::OP_MAX:      data_next.res = gt ? operand_a : operand_b;
      fpa_pkg::OP_INC:      data_next.res = operand_a + fpa_pkg::DATA_W'(1);
      fpa_pkg::OP_DEC:      data_next.res = operand_a - fpa_pkg::DATA_W'(1);
      fpa_pkg::OP_FROM_INT: data_next.res = operand_a << fpa_pkg::FRAC_BITS;
      fpa_pkg::OP_TO_INT:   data_next.res = to_int_c;
      default:              data_next.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
    if (advance) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== hw/rtl/fpa_div_cell.sv =====
// One cell of the divider chain: a restoring step producing one quotient bit.
// Items that are not divides pass through unchanged. Depends on fpa_pkg.
module fpa_div_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             in_valid,
  input  fpa_pkg::cell_t   in_data,
  output logic             out_valid,
  output fpa_pkg::cell_t   out_data
);

  fpa_pkg::cell_t                  data_next;
  logic [fpa_pkg::DATA_W+1:0]      trial;
  logic                            fits;

  always_comb begin
    // remainder < divisor <= 2^31, so shifted remainder fits DATA_W+1 bits
    trial = {1'b0, in_data.rem, in_data.dvd[fpa_pkg::DIV_W-1]}
            - {2'b00, in_data.dvs};
    fits  = !trial[fpa_pkg::DATA_W+1];

    data_next = in_data;
    if (in_data.is_div) begin
      data_next.dvd = in_data.dvd << 1;
      data_next.rem = fits ? trial[fpa_pkg::DATA_W-1:0]
                           : {in_data.rem[fpa_pkg::DATA_W-2:0],
                              in_data.dvd[fpa_pkg::DIV_W-1]};
      // only the low quotient bits survive the final wrap
      data_next.q   = {in_data.q[fpa_pkg::DATA_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
    if (advance) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== hw/rtl/fpa_back.sv =====
// Output stage: applies the quotient sign and the zero-divisor rule,
// and holds the result until it is taken. Depends on fpa_pkg.
module fpa_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               advance,
  input  logic                               in_valid,
  input  fpa_pkg::cell_t                     in_data,
  output logic                               out_valid,
  output logic signed [fpa_pkg::DATA_W-1:0]  value,
  output logic                               flag,
  output logic                               div_by_zero
);

  logic [fpa_pkg::DATA_W-1:0] value_next;

  always_comb begin
    if (in_data.dz) begin
      value_next = '0;
    end else if (in_data.is_div && in_data.neg) begin
      value_next = -in_data.q;
    end else begin
      value_next = in_data.q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
    if (advance) begin
      value       <= value_next;
      flag        <= in_data.flag;
      div_by_zero <= in_data.dz;
    end
  end

endmodule

// ===== hw/rtl/fixed_point_alu_unit.sv =====
// Signed 32-bit Q24.8 fixed-point ALU. Takes one transaction per clock and
// returns one result per transaction, in order, through its registers in turn:
// an entry stage, a chain of 40 divider cells (one quotient bit each, one
// per magnitude bit of the widened dividend) and an output register. Every
// opcode travels the same chain, so latency does not depend on the opcode.
// The whole pipeline moves together and stalls only while a result sits
// unclaimed in the output register. Depends on fpa_pkg, fpa_front,
// fpa_div_cell, fpa_back and fixed_point_alu_unit_defines.svh.
`include "fixed_point_alu_unit_defines.svh"

module fixed_point_alu_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  logic [fpa_pkg::KIND_W-1:0]         kind,
  input  logic signed [fpa_pkg::DATA_W-1:0]  operand_a,
  input  logic signed [fpa_pkg::DATA_W-1:0]  operand_b,
  output logic                               rsp_valid,
  input  logic                               rsp_ready,
  output logic signed [fpa_pkg::DATA_W-1:0]  value,
  output logic                               flag,
  output logic                               div_by_zero
);

  logic                                  advance;
  logic                                  front_valid;
  fpa_pkg::front_t                       front_data;
  logic signed [2*fpa_pkg::DATA_W-1:0]   prod_s;
  logic signed [2*fpa_pkg::DATA_W-1:0]   prod_shift;
  fpa_pkg::cell_t                        chain_head;
  logic [fpa_pkg::DIV_W:0]               chain_valid;
  fpa_pkg::cell_t                        chain_data [fpa_pkg::DIV_W+1];

  assign advance   = !rsp_valid || rsp_ready;
  assign req_ready = advance;

  fpa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (req_valid),
    .kind      (kind),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .out_valid (front_valid),
    .out_data  (front_data)
  );

  // product was registered in the entry stage; scale it on the way in
  always_comb begin
    prod_s     = front_data.prod;
    prod_shift = prod_s >>> fpa_pkg::FRAC_BITS;

    chain_head.is_div = front_data.is_div;
    chain_head.dz     = front_data.dz;
    chain_head.neg    = front_data.neg;
    chain_head.flag   = front_data.flag;
    chain_head.rem    = '0;
    chain_head.dvd    = front_data.dvd;
    chain_head.dvs    = front_data.dvs;
    chain_head.q      = front_data.is_div ? '0
                      : front_data.is_mul ? prod_shift[fpa_pkg::DATA_W-1:0]
                      : front_data.res;
  end

  assign chain_valid[0] = front_valid;
  assign chain_data[0]  = chain_head;

  for (genvar i = 0; i < fpa_pkg::DIV_W; i++) begin : g_cell
    fpa_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .in_valid  (chain_valid[i]),
      .in_data   (chain_data[i]),
      .out_valid (chain_valid[i+1]),
      .out_data  (chain_data[i+1])
    );
  end

  fpa_back u_back (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .in_valid    (chain_valid[fpa_pkg::DIV_W]),
    .in_data     (chain_data[fpa_pkg::DIV_W]),
    .out_valid   (rsp_valid),
    .value       (value),
    .flag        (flag),
    .div_by_zero (div_by_zero)
  );

  `FPA_ASSERT_IMPLY(a_flag_dz_excl, rsp_valid, !(flag && div_by_zero), "flag and div_by_zero both set")
  `FPA_ASSERT_IMPLY(a_dz_zero_value, rsp_valid && div_by_zero, value == '0, "div by zero with nonzero value")
  `FPA_ASSERT_IMPLY(a_cmp_zero_value, rsp_valid && flag, value == '0, "comparison with nonzero value")

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for fixed_point_alu_unit: directed corner cases, then random ops.
// Needs fpa_pkg and the fixed_point_alu_unit RTL. Expected results come from a local
// Q-format model, and a small scoreboard checks them in order.
module tb;

  localparam int DATA_W     = fpa_pkg::DATA_W;
  localparam int FRAC_BITS  = fpa_pkg::FRAC_BITS;
  localparam int KIND_W     = fpa_pkg::KIND_W;
  localparam int RAND_ITEMS = 650;
  localparam int PIPE_LAT   = fpa_pkg::DIV_W + 2;
  localparam logic signed [DATA_W-1:0] RAW_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] RAW_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     flag;
    logic                     dz;
  } alu_result_t;

  class alu_scoreboard;
    alu_result_t expected_q[$];
    int unsigned mismatches = 0;

    function alu_result_t alu_compute(fpa_pkg::op_t op, logic signed [DATA_W-1:0] a,
                                      logic signed [DATA_W-1:0] b);
      logic signed [2*DATA_W-1:0] wide_a;
      logic signed [2*DATA_W-1:0] wide_b;
      logic signed [2*DATA_W-1:0] wide_r;
      logic signed [2*DATA_W-1:0] scale;
      alu_result_t r;
      wide_a  = (2*DATA_W)'(a);
      wide_b  = (2*DATA_W)'(b);
      scale   = 64'sd1 <<< FRAC_BITS;
      wide_r  = '0;
      r.value = '0;
      r.flag  = 1'b0;
      r.dz    = 1'b0;
      case (op)
        fpa_pkg::OP_ADD: r.value = a + b;
        fpa_pkg::OP_SUB: r.value = a - b;
        fpa_pkg::OP_MUL: begin
          wide_r  = (wide_a * wide_b) >>> FRAC_BITS;
          r.value = wide_r[DATA_W-1:0];
        end
        fpa_pkg::OP_DIV: begin
          if (b == 0) begin
            r.dz = 1'b1;
          end else begin
            // dividend widened first so the shift cannot lose the top bits
            wide_r  = (wide_a <<< FRAC_BITS) / wide_b;
            r.value = wide_r[DATA_W-1:0];
          end
        end
        fpa_pkg::OP_GT:       r.flag  = (a > b);
        fpa_pkg::OP_LT:       r.flag  = (a < b);
        fpa_pkg::OP_GE:       r.flag  = (a >= b);
        fpa_pkg::OP_LE:       r.flag  = (a <= b);
        fpa_pkg::OP_EQ:       r.flag  = (a == b);
        fpa_pkg::OP_NE:       r.flag  = (a != b);
        fpa_pkg::OP_MIN:      r.value = (a < b) ? a : b;
        fpa_pkg::OP_MAX:      r.value = (a > b) ? a : b;
        fpa_pkg::OP_INC:      r.value = a + 32'sd1;
        fpa_pkg::OP_DEC:      r.value = a - 32'sd1;
        fpa_pkg::OP_FROM_INT: r.value = a <<< FRAC_BITS;
        default: begin
          wide_r  = wide_a / scale;
          r.value = wide_r[DATA_W-1:0];
        end
      endcase
      return r;
    endfunction

    function void log_request(fpa_pkg::op_t op, logic signed [DATA_W-1:0] a,
                              logic signed [DATA_W-1:0] b);
      expected_q.push_back(alu_compute(op, a, b));
    endfunction

    function void check_response(logic signed [DATA_W-1:0] value, logic flag, logic dz);
      alu_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction: value %0d flag %0b div_by_zero %0b",
               value, flag, dz);
        mismatches++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (value !== exp_r.value) begin
        $error("value mismatch: expected %0d, actual %0d", exp_r.value, value);
        mismatches++;
      end
      if (flag !== exp_r.flag) begin
        $error("flag mismatch: expected %0b, actual %0b", exp_r.flag, flag);
        mismatches++;
      end
      if (dz !== exp_r.dz) begin
        $error("div_by_zero mismatch: expected %0b, actual %0b", exp_r.dz, dz);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      req_valid = 1'b0;
  logic                      req_ready;
  logic [KIND_W-1:0]         kind = '0;
  logic signed [DATA_W-1:0]  operand_a = '0;
  logic signed [DATA_W-1:0]  operand_b = '0;
  logic                      rsp_valid;
  logic                      rsp_ready = 1'b0;
  logic signed [DATA_W-1:0]  value;
  logic                      flag;
  logic                      div_by_zero;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  alu_scoreboard sb = new();

  fixed_point_alu_unit dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .kind        (kind),
    .operand_a   (operand_a),
    .operand_b   (operand_b),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .value       (value),
    .flag        (flag),
    .div_by_zero (div_by_zero)
  );

  always #5 clk = ~clk;

  // response side: random backpressure, check every accepted transaction
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      sb.check_response(value, flag, div_by_zero);
    end
    rsp_ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
  end

  // called just after a rising edge; returns at the edge that accepts the transaction
  task automatic send_op(fpa_pkg::op_t op, logic signed [DATA_W-1:0] a,
                         logic signed [DATA_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    kind      <= op;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.log_request(op, a, b);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_operand();
    case ($urandom_range(7))
      0: return RAW_MIN;
      1: return RAW_MAX;
      2: return '0;
      3: return $signed($urandom_range(511)) - 256;
      4: return ($signed($urandom_range(64)) - 32) <<< FRAC_BITS;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random();
    fpa_pkg::op_t op;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    op = fpa_pkg::op_t'($urandom_range(15));
    a  = pick_operand();
    b  = pick_operand();
    if ($urandom_range(7) == 0) b = a;
    if (op == fpa_pkg::OP_DIV && $urandom_range(7) == 0) b = '0;
    send_op(op, a, b);
  endtask

  task automatic run_directed();
    send_op(fpa_pkg::OP_ADD, RAW_MAX, 32'sd1);
    send_op(fpa_pkg::OP_ADD, RAW_MIN, RAW_MIN);
    send_op(fpa_pkg::OP_SUB, RAW_MIN, 32'sd1);
    send_op(fpa_pkg::OP_SUB, 32'sd0, RAW_MIN);
    send_op(fpa_pkg::OP_MUL, RAW_MAX, RAW_MAX);
    send_op(fpa_pkg::OP_MUL, RAW_MIN, RAW_MIN);
    send_op(fpa_pkg::OP_MUL, -32'sd1, 32'sd1);
    send_op(fpa_pkg::OP_MUL, 32'sh180, -32'sh200);
    send_op(fpa_pkg::OP_DIV, 32'sh100, 32'sd0);
    send_op(fpa_pkg::OP_DIV, RAW_MIN, -32'sd1);   // quotient overflows and wraps
    send_op(fpa_pkg::OP_DIV, -32'sh300, 32'sh200);
    send_op(fpa_pkg::OP_DIV, -32'sd1, 32'sd3);    // truncates toward zero
    send_op(fpa_pkg::OP_GT, RAW_MAX, RAW_MIN);
    send_op(fpa_pkg::OP_LT, RAW_MIN, RAW_MAX);
    send_op(fpa_pkg::OP_GE, 32'sd5, 32'sd5);
    send_op(fpa_pkg::OP_LE, RAW_MIN, RAW_MIN);
    send_op(fpa_pkg::OP_EQ, -32'sd1, -32'sd1);
    send_op(fpa_pkg::OP_NE, 32'sd0, RAW_MIN);
    send_op(fpa_pkg::OP_MIN, RAW_MIN, RAW_MAX);
    send_op(fpa_pkg::OP_MAX, 32'sd7, 32'sd7);
    send_op(fpa_pkg::OP_INC, RAW_MAX, RAW_MIN);
    send_op(fpa_pkg::OP_DEC, RAW_MIN, RAW_MAX);
    send_op(fpa_pkg::OP_FROM_INT, RAW_MAX, 32'sd0);
    send_op(fpa_pkg::OP_TO_INT, -32'sd1, 32'sd0);
    send_op(fpa_pkg::OP_TO_INT, RAW_MIN, -32'sd1);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 11;
          recv_idle_pct = 81;
        end
        1: begin
          send_idle_pct = 81;
          recv_idle_pct = 11;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (phase == 0) run_directed();
      repeat (RAND_ITEMS / 3) send_random();
    end
    req_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (2 * PIPE_LAT) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("[fixed_point_alu_unit] OK");
    end else begin
      $display("[fixed_point_alu_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[fixed_point_alu_unit] ERROR");
    $finish;
  end
endmodule
